FILE: design/modinv_pkg.sv
`default_nettype none
package modinv_pkg;

  // Fixed field widths on the stream ports
  localparam int FIELD_W    = 64;
  localparam int IN_DATA_W  = 2 * FIELD_W;  // value_in, modulus
  localparam int OUT_DATA_W = FIELD_W;      // inverse

endpackage
`default_nettype wire

FILE: design/modular_inverse_ext_euclid_unit.sv
// Modular inverse by extended Euclid: one item in flight at a time.
// Each Euclid step runs check, then align and divide, each at one quotient bit per cycle,
//   then update; s_tready is high only when idle, so no new item is taken until the result
//   has been accepted.
// Reset (rst, synchronous, active high) returns the sequencer to idle and
//   drops m_tvalid; datapath registers are not cleared.
`default_nettype none
module modular_inverse_ext_euclid_unit #(
  parameter int WIDTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata: [63:0] value_in, [127:64] modulus
  input  wire logic [modinv_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // m_tdata: [63:0] inverse
  output logic [modinv_pkg::OUT_DATA_W-1:0]     m_tdata,
  // m_tuser: [0] inverse_exists
  output logic                                  m_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready
);

  localparam int KW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    IDLE, CHECK, ALIGN, DIV, UPDATE, REDUCE, FINISH, DONE
  } state_t;

  state_t state;

  // Euclid remainders and Bezout magnitudes of the value
  logic [WIDTH-1:0] r0, r1, modulus, prev_mag, cur_mag;
  logic             odd;            // parity of the step count
  // Shared divide unit: aligned divisor, partial remainder, q*cur_mag
  logic [WIDTH-1:0] dvs, rem, acc;
  logic [KW-1:0]    shift_cnt;
  logic [WIDTH-1:0] inverse;
  logic             inverse_exists;

  logic             can_shift;
  logic             sub_ok;
  logic [WIDTH-1:0] rem_next, acc_next;

  assign s_tready = (state == IDLE);
  assign m_tdata  = modinv_pkg::OUT_DATA_W'(inverse);
  assign m_tuser  = inverse_exists;

  // Divisor may double without passing the dividend
  assign can_shift = !dvs[WIDTH-1] && ({dvs[WIDTH-2:0], 1'b0} <= r0);

  // One restoring division step; the quotient bit folds straight into q*cur_mag
  always_comb begin
    sub_ok   = (rem >= dvs);
    rem_next = sub_ok ? rem - dvs : rem;
    acc_next = {acc[WIDTH-2:0], 1'b0} + (sub_ok ? cur_mag : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            r0       <= s_tdata[WIDTH-1:0];
            r1       <= s_tdata[modinv_pkg::FIELD_W +: WIDTH];
            modulus  <= s_tdata[modinv_pkg::FIELD_W +: WIDTH];
            prev_mag <= WIDTH'(1);
            cur_mag  <= '0;
            odd      <= 1'b0;
            state    <= CHECK;
          end
        end
        CHECK: begin
          if (r1 == '0) begin
            state <= REDUCE;
          end else begin
            dvs       <= r1;
            shift_cnt <= '0;
            state     <= ALIGN;
          end
        end
        ALIGN: begin
          if (can_shift) begin
            dvs       <= {dvs[WIDTH-2:0], 1'b0};
            shift_cnt <= shift_cnt + KW'(1);
          end else begin
            rem   <= r0;
            acc   <= '0;
            state <= DIV;
          end
        end
        DIV: begin
          rem <= rem_next;
          acc <= acc_next;
          dvs <= dvs >> 1;
          if (shift_cnt == '0) begin
            state <= UPDATE;
          end else begin
            shift_cnt <= shift_cnt - KW'(1);
          end
        end
        UPDATE: begin
          // rem = r0 mod r1, acc = (r0 / r1) * cur_mag
          r0       <= r1;
          r1       <= rem;
          prev_mag <= cur_mag;
          cur_mag  <= prev_mag + acc;
          odd      <= !odd;
          state    <= CHECK;
        end
        REDUCE: begin
          // negative coefficient: magnitude is at most m, one subtract reduces it
          if (odd && (prev_mag >= modulus)) begin
            prev_mag <= prev_mag - modulus;
          end
          state <= FINISH;
        end
        FINISH: begin
          inverse_exists <= (r0 == WIDTH'(1));
          if (r0 != WIDTH'(1)) begin
            inverse <= '0;
          end else if (!odd || prev_mag == '0) begin
            inverse <= prev_mag;
          end else begin
            inverse <= modulus - prev_mag;
          end
          m_tvalid <= 1'b1;
          state    <= DONE;
        end
        DONE: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/modinv_checker.sv
`default_nettype none
module modinv_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [modinv_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                             m_tuser,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready
);

  // A pending result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped or changed while stalled");

  // No new item is taken while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while result pending");

  // An accepted item cannot produce its result on the next edge
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid)
    else $error("result appeared too early");

  // No inverse means a zero inverse field
  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("nonzero inverse flagged as absent");

endmodule

bind modular_inverse_ext_euclid_unit modinv_checker u_modinv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire
